@@ sv/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
// No dependencies; the assertions compile away when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("scheduler assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("scheduler implication failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/srtf_pkg.sv @@
// Shared types and constants for the shortest-remaining-time-first scheduler.
// No dependencies.
package srtf_pkg;

  localparam int unsigned MAX_JOBS_DEF  = 16;
  localparam int unsigned TIME_BITS_DEF = 16;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned FIELD_W       = 16;
  localparam int unsigned IN_DATA_W     = 40;
  localparam int unsigned OUT_DATA_W    = 48;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
  } slot_wr_t;

  typedef struct packed {
    logic               found;
    logic [ID_W-1:0]    id;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] remaining;
  } cand_t;

endpackage

@@ sv/srtf_tick_scheduler.sv @@
// Shortest-remaining-time-first scheduler: a row of MAX_JOBS slot cells.
// An add goes from IDLE to COMMIT, which registers its result; a tick first passes through
// SCAN, where the best candidate moves one cell per cycle, and then through COMMIT.
// A new add or tick is taken only in IDLE, once the previous result has left COMMIT.
// Reset clears the timer, the job count, the done flags and the chart state at
// once; slot contents are only read after an add has written them.
module srtf_tick_scheduler #(
  parameter int unsigned MAX_JOBS  = srtf_pkg::MAX_JOBS_DEF,
  parameter int unsigned TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // job_id[7:0], arrival_time[23:8], burst_time[39:24]
  input  logic [srtf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd[0]
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // running_valid[0], running_id[8:1], new_segment[9], finished[10],
  // turnaround[26:11], waiting[42:27], table_full[43], zeros[47:44]
  output logic [srtf_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import srtf_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IDX_W = $clog2(MAX_JOBS);
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned CMP_W = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     scan_cnt_q, scan_cnt_d;
  logic [CNT_W-1:0]     job_count_q, job_count_d;
  logic [TIME_BITS-1:0] clock_q, clock_d, clock_next;
  logic [ID_W-1:0]      last_id_q, last_id_d;
  logic                 chart_q, chart_d;
  cmd_e                 cmd_q;
  slot_wr_t             item_q;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                 accept;
  logic                 out_free;
  logic                 commit;
  logic                 add_ok;
  logic                 run;
  logic                 finish;
  logic                 new_seg;
  logic [CMP_W-1:0]     tat, wt;
  logic [FIELD_W-1:0]   tat_sat, wt_sat;

  logic [MAX_JOBS-1:0]  wr_en;
  logic [MAX_JOBS-1:0]  dec_en;
  logic [MAX_JOBS-1:0]  occupied;
  cand_t                cand   [MAX_JOBS+1];
  logic [IDX_W-1:0]     idx    [MAX_JOBS+1];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign commit   = (state_q == ST_COMMIT) && out_free;

  assign cand[0] = '0;
  assign idx[0]  = '0;

  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
    assign occupied[k] = (job_count_q > CNT_W'(k));
    assign wr_en[k]    = commit && (cmd_q == CMD_ADD) && add_ok &&
                         (job_count_q[IDX_W-1:0] == IDX_W'(k));
    assign dec_en[k]   = commit && run && (idx[MAX_JOBS] == IDX_W'(k));

    srtf_cell #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS),
      .SLOT      (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en[k]),
      .wr_i       (item_q),
      .dec_en_i   (dec_en[k]),
      .occupied_i (occupied[k]),
      .clock_i    (clock_q),
      .cand_i     (cand[k]),
      .idx_i      (idx[k]),
      .cand_o     (cand[k+1]),
      .idx_o      (idx[k+1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (cmd_e'(s_axis_tuser[0]) == CMD_TICK) ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q == IDX_W'(MAX_JOBS - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    scan_cnt_d    = (state_q == ST_SCAN) ? scan_cnt_q + IDX_W'(1) : '0;

    add_ok     = (job_count_q != CNT_W'(MAX_JOBS));
    run        = (cmd_q == CMD_TICK) && cand[MAX_JOBS].found;
    clock_next = (clock_q == '1) ? clock_q : clock_q + TIME_BITS'(1);
    finish     = run && (cand[MAX_JOBS].remaining == FIELD_W'(1));
    new_seg    = run && (!chart_q || last_id_q != cand[MAX_JOBS].id);
    tat        = CMP_W'(clock_next) - CMP_W'(cand[MAX_JOBS].arrival);
    wt         = (tat > CMP_W'(cand[MAX_JOBS].burst)) ?
                 tat - CMP_W'(cand[MAX_JOBS].burst) : '0;
    tat_sat    = (tat > CMP_W'(16'hFFFF)) ? 16'hFFFF : tat[FIELD_W-1:0];
    wt_sat     = (wt > CMP_W'(16'hFFFF)) ? 16'hFFFF : wt[FIELD_W-1:0];

    job_count_d = job_count_q;
    clock_d     = clock_q;
    last_id_d   = last_id_q;
    chart_d     = chart_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    if (commit) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      if (cmd_q == CMD_ADD) begin
        if (add_ok) begin
          job_count_d = job_count_q + CNT_W'(1);
        end else begin
          out_data_d[43] = 1'b1;
        end
      end else begin
        clock_d = clock_next;
        if (run) begin
          out_data_d[0]     = 1'b1;
          out_data_d[8:1]   = cand[MAX_JOBS].id;
          out_data_d[9]     = new_seg;
          out_data_d[10]    = finish;
          if (finish) begin
            out_data_d[26:11] = tat_sat;
            out_data_d[42:27] = wt_sat;
          end
          if (new_seg) begin
            chart_d   = 1'b1;
            last_id_d = cand[MAX_JOBS].id;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_cnt_q  <= '0;
      job_count_q <= '0;
      clock_q     <= '0;
      last_id_q   <= '0;
      chart_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      job_count_q <= job_count_d;
      clock_q     <= clock_d;
      last_id_q   <= last_id_d;
      chart_q     <= chart_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      cmd_q          <= cmd_e'(s_axis_tuser[0]);
      item_q.id      <= s_axis_tdata[7:0];
      item_q.arrival <= s_axis_tdata[23:8];
      item_q.burst   <= s_axis_tdata[39:24];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, job_count_q <= CNT_W'(MAX_JOBS))
  `ASSERT_IMPLIES(a_rise_from_commit, clk_i, rst_ni, $rose(out_valid_q),
                  $past(state_q) == ST_COMMIT)
  `ASSERT_IMPLIES(a_finish_runs, clk_i, rst_ni, out_valid_q && out_data_q[10],
                  out_data_q[0] && !out_data_q[43])
  `ASSERT_IMPLIES(a_full_refused, clk_i, rst_ni, commit && cmd_q == CMD_ADD && !add_ok,
                  job_count_q == CNT_W'(MAX_JOBS))

endmodule

@@ sv/srtf_cell.sv @@
// One job slot of the scheduler chain: holds the slot and passes the best candidate on.
// Depends on srtf_pkg.
module srtf_cell #(
  parameter int unsigned MAX_JOBS  = srtf_pkg::MAX_JOBS_DEF,
  parameter int unsigned TIME_BITS = srtf_pkg::TIME_BITS_DEF,
  parameter int unsigned SLOT      = 0,
  localparam int unsigned IDX_W    = $clog2(MAX_JOBS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  srtf_pkg::slot_wr_t       wr_i,
  input  logic                     dec_en_i,
  input  logic                     occupied_i,
  input  logic [TIME_BITS-1:0]     clock_i,
  input  srtf_pkg::cand_t          cand_i,
  input  logic [IDX_W-1:0]         idx_i,
  output srtf_pkg::cand_t          cand_o,
  output logic [IDX_W-1:0]         idx_o
);
  import srtf_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  logic [ID_W-1:0]    id_q;
  logic [FIELD_W-1:0] arrival_q;
  logic [FIELD_W-1:0] burst_q;
  logic [FIELD_W-1:0] rem_q;
  logic               done_q;
  logic               eligible;
  logic               take;
  cand_t              cand_d, cand_q;
  logic [IDX_W-1:0]   idx_d, idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_q      <= wr_i.id;
      arrival_q <= wr_i.arrival;
      burst_q   <= wr_i.burst;
      rem_q     <= wr_i.burst;
    end else if (dec_en_i) begin
      rem_q <= rem_q - FIELD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (wr_en_i) begin
      done_q <= (wr_i.burst == '0);
    end else if (dec_en_i && rem_q == FIELD_W'(1)) begin
      done_q <= 1'b1;
    end
  end

  always_comb begin
    eligible = occupied_i && !done_q && (CMP_W'(arrival_q) <= CMP_W'(clock_i));
    take     = eligible && (!cand_i.found || rem_q < cand_i.remaining);
    if (take) begin
      cand_d.found     = 1'b1;
      cand_d.id        = id_q;
      cand_d.arrival   = arrival_q;
      cand_d.burst     = burst_q;
      cand_d.remaining = rem_q;
      idx_d            = IDX_W'(SLOT);
    end else begin
      cand_d = cand_i;
      idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      idx_q  <= '0;
    end else begin
      cand_q <= cand_d;
      idx_q  <= idx_d;
    end
  end

  assign cand_o = cand_q;
  assign idx_o  = idx_q;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for srtf_tick_scheduler: it drives job adds and ticks
// over the input stream, predicts each result, and checks the output stream.
// Depends on srtf_pkg and the scheduler RTL.
module tb;
  import srtf_pkg::*;

  localparam int unsigned SLOTS = MAX_JOBS_DEF;
  localparam int TIMER_TOP = (1 << TIME_BITS_DEF) - 1;
  localparam int RANDOM_ITEMS = 560;
  localparam int NO_IDLE_TICKS = 40;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic               table_full;
    logic [FIELD_W-1:0] waiting;
    logic [FIELD_W-1:0] turnaround;
    logic               finished;
    logic               new_segment;
    logic [ID_W-1:0]    running_id;
    logic               running_valid;
  } sched_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [ID_W-1:0]    job_tag [SLOTS];
  logic [FIELD_W-1:0] job_arrival [SLOTS];
  logic [FIELD_W-1:0] job_burst [SLOTS];
  logic [FIELD_W-1:0] job_left [SLOTS];
  logic               job_done [SLOTS];
  int                 jobs_stored = 0;
  int                 sched_now = 0;
  logic [ID_W-1:0]    chart_id = '0;
  logic               chart_open = 1'b0;

  sched_result_t pending_results[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            idle_on = 1'b1;

  srtf_tick_scheduler DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 11);
  end

  function automatic sched_result_t schedule_step(cmd_e cmd, logic [ID_W-1:0] id,
                                                  logic [FIELD_W-1:0] arr,
                                                  logic [FIELD_W-1:0] bur);
    sched_result_t r;
    int pick;
    int tat;
    r = '0;
    pick = -1;
    if (cmd == CMD_ADD) begin
      if (jobs_stored >= SLOTS) begin
        r.table_full = 1'b1;
      end else begin
        job_tag[jobs_stored] = id;
        job_arrival[jobs_stored] = arr;
        job_burst[jobs_stored] = bur;
        job_left[jobs_stored] = bur;
        job_done[jobs_stored] = (bur == 0);
        jobs_stored++;
      end
      return r;
    end
    for (int k = 0; k < jobs_stored; k++) begin
      if (!job_done[k] && int'(job_arrival[k]) <= sched_now) begin
        if (pick < 0 || job_left[k] < job_left[pick]) pick = k;
      end
    end
    if (sched_now < TIMER_TOP) sched_now++;
    if (pick < 0) return r;
    r.running_valid = 1'b1;
    r.running_id = job_tag[pick];
    if (!chart_open || chart_id != job_tag[pick]) begin
      r.new_segment = 1'b1;
      chart_open = 1'b1;
      chart_id = job_tag[pick];
    end
    job_left[pick]--;
    if (job_left[pick] == 0) begin
      tat = sched_now - int'(job_arrival[pick]);
      if (tat > TIMER_TOP) tat = TIMER_TOP;
      job_done[pick] = 1'b1;
      r.finished = 1'b1;
      r.turnaround = tat[FIELD_W-1:0];
      r.waiting = (tat > int'(job_burst[pick])) ? FIELD_W'(tat - int'(job_burst[pick])) : '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(sched_result_t)-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(got), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.running_valid !== want.running_valid)
          report_mismatch("running_valid", 64'(got.running_valid),
                          64'(want.running_valid));
        if (got.running_id !== want.running_id)
          report_mismatch("running_id", 64'(got.running_id), 64'(want.running_id));
        if (got.new_segment !== want.new_segment)
          report_mismatch("new_segment", 64'(got.new_segment), 64'(want.new_segment));
        if (got.finished !== want.finished)
          report_mismatch("finished", 64'(got.finished), 64'(want.finished));
        if (got.turnaround !== want.turnaround)
          report_mismatch("turnaround", 64'(got.turnaround), 64'(want.turnaround));
        if (got.waiting !== want.waiting)
          report_mismatch("waiting", 64'(got.waiting), 64'(want.waiting));
        if (got.table_full !== want.table_full)
          report_mismatch("table_full", 64'(got.table_full), 64'(want.table_full));
      end
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [ID_W-1:0] id,
                           input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] bur);
    if (idle_on && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {bur, arr, id};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_results.push_back(schedule_step(cmd, id, arr, bur));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_idle_ticks();
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_TICK, '1, '1, '1);
  endtask

  task automatic test_job_extremes();
    send_item(CMD_ADD, 8'h00, 16'h0000, 16'h0001);
    send_item(CMD_ADD, 8'hFF, 16'hFFFF, 16'h0003);
    send_item(CMD_ADD, 8'h5A, 16'h0000, 16'h0000);
    send_item(CMD_ADD, 8'hC3, 16'h0000, 16'hFFFF);
    repeat (3) send_item(CMD_TICK, '0, '0, '0);
  endtask

  task automatic test_tie_and_same_id();
    send_item(CMD_ADD, 8'h11, FIELD_W'(sched_now), 16'd2);
    send_item(CMD_ADD, 8'h22, FIELD_W'(sched_now), 16'd2);
    repeat (3) send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_ADD, 8'h22, FIELD_W'(sched_now), 16'd1);
    repeat (2) send_item(CMD_TICK, '0, '0, '0);
  endtask

  task automatic test_random_schedule();
    logic [FIELD_W-1:0] arr;
    logic [FIELD_W-1:0] bur;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      if ($urandom_range(0, 19) == 0) begin
        if (jobs_stored < SLOTS) begin
          arr = ($urandom_range(0, 7) == 0) ? FIELD_W'(sched_now + $urandom_range(0, 2000))
                                            : FIELD_W'(sched_now + $urandom_range(0, 24));
          bur = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom_range(1, 300))
                                            : FIELD_W'($urandom_range(1, 32));
          send_item(CMD_ADD, ID_W'($urandom), arr, bur);
        end else begin
          send_item(CMD_ADD, ID_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        end
      end else begin
        send_item(CMD_TICK, ID_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
      end
    end
  endtask

  task automatic test_table_full();
    while (jobs_stored < SLOTS) begin
      send_item(CMD_ADD, ID_W'($urandom), FIELD_W'(sched_now + $urandom_range(0, 20)),
                FIELD_W'($urandom_range(1, 16)));
    end
    repeat (3) send_item(CMD_ADD, ID_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
  endtask

  task automatic test_no_idle_burst();
    idle_on = 1'b0;
    repeat (NO_IDLE_TICKS) send_item(CMD_TICK, '0, '0, '0);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_ticks();
    test_job_extremes();
    test_tie_and_same_id();
    test_random_schedule();
    test_table_full();
    test_no_idle_burst();
    drain_results();
    repeat (SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
